// File: hw/rtl/phh_pkg.sv
// ----------------------------------------------------------------------------
// phh_pkg
// Shared types, codes and defaults of the point projection histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package phh_pkg;

  // default sizes of the bin store
  localparam int unsigned DEFAULT_MAX_COLUMNS = 256;
  localparam int unsigned DEFAULT_MAX_ROWS    = 256;
  localparam int unsigned DEFAULT_COUNT_BITS  = 16;

  // fixed field widths
  localparam int unsigned OP_BITS     = 2;
  localparam int unsigned NUMBER_BITS = 16;
  localparam int unsigned COUNT_OUT   = 16;

  // queue depths between the parts
  localparam int unsigned FQ_DEPTH = 4;
  localparam int unsigned OQ_DEPTH = 2;

  // input command codes
  localparam logic [1:0] CMD_ADD        = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_V      = 3'd1;
  localparam logic [2:0] REG_SCALE_X       = 3'd2;
  localparam logic [2:0] REG_SCALE_V       = 3'd3;
  localparam logic [2:0] REG_RASTER_WIDTH  = 3'd4;
  localparam logic [2:0] REG_RASTER_HEIGHT = 3'd5;
  localparam logic [2:0] REG_PLANE_SELECT  = 3'd6;

  // operation handed from the front to the back
  typedef enum logic [OP_BITS-1:0] {
    OP_NONE  = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // configuration register set
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_v;
    logic [31:0]        scale_x;
    logic [31:0]        scale_v;
    logic [8:0]         raster_width;
    logic [8:0]         raster_height;
    logic               plane_select;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic                   counted;
    logic [NUMBER_BITS-1:0] bin_number;
    logic [COUNT_OUT-1:0]   bin_count;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/phh_ram.sv
// ----------------------------------------------------------------------------
// phh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module phh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first: a read of the word being written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/phh_queue.sv
// ----------------------------------------------------------------------------
// phh_queue
// Small first-word fall-through queue held in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module phh_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic                  full
);

  localparam int unsigned PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PB-1:0]    head;
  logic [PB-1:0]    tail;
  logic [CB-1:0]    fill;

  assign empty   = (fill == '0);
  assign full    = (fill == CB'(DEPTH));
  assign rd_data = slots[head];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      if (wr) begin
        tail <= (tail == PB'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (rd) begin
        head <= (head == PB'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (wr && !rd) begin
        fill <= fill + 1'b1;
      end else if (rd && !wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/phh_front.sv
// ----------------------------------------------------------------------------
// phh_front
// Takes command beats, projects points onto the raster and classifies each
// beat into a store operation with its bin address, over four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module phh_front #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned STORE_SIZE  = 65536,
  parameter int unsigned ADDR_BITS   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire phh_pkg::cfg_t       cfg,
  input  wire logic                take,
  input  wire logic [1:0]          cmd,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire logic signed [31:0]  point_z,
  input  wire logic [15:0]         read_index,
  output logic                     ready,
  output logic                     q_push,
  output logic [phh_pkg::OP_BITS+phh_pkg::NUMBER_BITS+ADDR_BITS-1:0] q_entry,
  input  wire logic                q_full
);

  import phh_pkg::*;

  localparam int unsigned WB = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned HB = $clog2(MAX_ROWS + 1);
  localparam int unsigned CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned BW = WB + RB;

  typedef struct packed {
    op_t                    op;
    logic [NUMBER_BITS-1:0] number;
    logic [ADDR_BITS-1:0]   addr;
  } entry_t;

  // clamped raster size
  logic [31:0]   rw32;
  logic [31:0]   rh32;
  logic [WB-1:0] w_lim;
  logic [HB-1:0] h_lim;

  assign rw32  = 32'(cfg.raster_width);
  assign rh32  = 32'(cfg.raster_height);
  assign w_lim = (rw32 > MAX_COLUMNS) ? WB'(MAX_COLUMNS) : rw32[WB-1:0];
  assign h_lim = (rh32 > MAX_ROWS) ? HB'(MAX_ROWS) : rh32[HB-1:0];

  // whole pipeline moves unless the last stage cannot hand over
  logic d_valid;
  assign ready  = !d_valid || !q_full;
  assign q_push = d_valid && !q_full;

  // ---- stage a inputs: difference and magnitude, command decode
  logic signed [31:0] pv_sel;
  logic signed [32:0] diff_x;
  logic signed [32:0] diff_v;
  logic [31:0]        ridx32;
  op_t                op_in;
  logic [15:0]        number_in;

  assign pv_sel = cfg.plane_select ? point_z : point_y;
  assign diff_x = 33'(point_x) - 33'(cfg.origin_x);
  assign diff_v = 33'(pv_sel) - 33'(cfg.origin_v);
  assign ridx32 = 32'(read_index);

  always_comb begin
    op_in     = OP_NONE;
    number_in = '0;
    unique case (cmd)
      CMD_ADD: begin
        op_in = OP_ADD;
      end
      CMD_READ: begin
        op_in     = (ridx32 < STORE_SIZE) ? OP_READ : OP_NONE;
        number_in = read_index;
      end
      CMD_READ_CLEAR: begin
        op_in     = (ridx32 < STORE_SIZE) ? OP_CLEAR : OP_NONE;
        number_in = read_index;
      end
      default: begin
        op_in = OP_NONE;
      end
    endcase
  end

  logic                 a_valid;
  op_t                  a_op;
  logic [15:0]          a_number;
  logic [ADDR_BITS-1:0] a_addr;
  logic                 a_neg_x;
  logic                 a_neg_v;
  logic [32:0]          a_mag_x;
  logic [32:0]          a_mag_v;

  // ---- stage b: low magnitude times scale, upper half kept
  logic [63:0] prod_x;
  logic [63:0] prod_v;

  assign prod_x = 64'(a_mag_x[31:0]) * 64'(cfg.scale_x);
  assign prod_v = 64'(a_mag_v[31:0]) * 64'(cfg.scale_v);

  logic                 b_valid;
  op_t                  b_op;
  logic [15:0]          b_number;
  logic [ADDR_BITS-1:0] b_addr;
  logic                 b_neg_x;
  logic                 b_neg_v;
  logic                 b_hi_x;
  logic                 b_hi_v;
  logic [31:0]          b_prod_x;
  logic [31:0]          b_prod_v;

  // ---- stage c: integer part and range check
  logic [32:0] whole_x;
  logic [32:0] whole_v;
  logic        in_x;
  logic        in_v;
  op_t         op_c;

  assign whole_x = {1'b0, b_prod_x} + (b_hi_x ? {1'b0, cfg.scale_x} : 33'd0);
  assign whole_v = {1'b0, b_prod_v} + (b_hi_v ? {1'b0, cfg.scale_v} : 33'd0);
  assign in_x    = (cfg.scale_x != '0) && !(b_neg_x && whole_x != '0)
                   && (whole_x < 33'(w_lim));
  assign in_v    = (cfg.scale_v != '0) && !(b_neg_v && whole_v != '0)
                   && (whole_v < 33'(h_lim));
  assign op_c    = (b_op == OP_ADD) ? ((in_x && in_v) ? OP_ADD : OP_NONE) : b_op;

  logic                 c_valid;
  op_t                  c_op;
  logic [15:0]          c_number;
  logic [ADDR_BITS-1:0] c_addr;
  logic [CB-1:0]        c_col;
  logic [RB-1:0]        c_row;

  // ---- stage d: row-major bin index
  logic [BW-1:0] bin_sum;
  logic [31:0]   bin32;

  assign bin_sum = BW'(c_col) + BW'(w_lim) * BW'(c_row);
  assign bin32   = 32'(bin_sum);

  entry_t d_entry;
  assign q_entry = d_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (ready) begin
      a_valid <= take;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (ready) begin
      a_op     <= op_in;
      a_number <= number_in;
      a_addr   <= ridx32[ADDR_BITS-1:0];
      a_neg_x  <= diff_x[32];
      a_neg_v  <= diff_v[32];
      a_mag_x  <= diff_x[32] ? 33'(-diff_x) : 33'(diff_x);
      a_mag_v  <= diff_v[32] ? 33'(-diff_v) : 33'(diff_v);

      b_op     <= a_op;
      b_number <= a_number;
      b_addr   <= a_addr;
      b_neg_x  <= a_neg_x;
      b_neg_v  <= a_neg_v;
      b_hi_x   <= a_mag_x[32];
      b_hi_v   <= a_mag_v[32];
      b_prod_x <= prod_x[63:32];
      b_prod_v <= prod_v[63:32];

      c_op     <= op_c;
      c_number <= b_number;
      c_addr   <= b_addr;
      c_col    <= whole_x[CB-1:0];
      c_row    <= whole_v[RB-1:0];

      d_entry.op     <= c_op;
      d_entry.number <= (c_op == OP_ADD) ? bin32[15:0] : c_number;
      d_entry.addr   <= (c_op == OP_ADD) ? bin_sum[ADDR_BITS-1:0] : c_addr;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/phh_back.sv
// ----------------------------------------------------------------------------
// phh_back
// Carries out store operations: read, update and write back the bin counts,
// with forwarding of the last write, and the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module phh_back #(
  parameter int unsigned STORE_SIZE = 65536,
  parameter int unsigned ADDR_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire logic [phh_pkg::OP_BITS+phh_pkg::NUMBER_BITS+ADDR_BITS-1:0] q_entry,
  output logic                   q_pop,
  input  wire logic              out_full,
  output logic                   out_push,
  output phh_pkg::result_t       out_result,
  output logic                   clearing
);

  import phh_pkg::*;

  typedef struct packed {
    op_t                    op;
    logic [NUMBER_BITS-1:0] number;
    logic [ADDR_BITS-1:0]   addr;
  } entry_t;

  entry_t head;
  assign head = q_entry;

  // clearing pass state
  logic [ADDR_BITS-1:0] clr_addr;

  // update stage, holds the beat whose read data is at the ram output
  logic                 w_valid;
  entry_t               w_entry;
  logic                 w_go;

  assign w_go     = w_valid && !out_full;
  assign q_pop    = !q_empty && !clearing && (!w_valid || !out_full);
  assign out_push = w_go;

  // last item write, newer than what a same-cycle read returned
  logic                  lw_valid;
  logic [ADDR_BITS-1:0]  lw_addr;
  logic [COUNT_BITS-1:0] lw_data;

  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic [COUNT_BITS-1:0] upd;
  logic [31:0]           cur32;
  logic [31:0]           inc32;
  logic                  item_we;

  assign cur   = (lw_valid && lw_addr == w_entry.addr) ? lw_data : rd_data;
  assign inc   = (&cur) ? cur : cur + 1'b1;
  assign cur32 = 32'(cur);
  assign inc32 = 32'(inc);

  // operation on the current count
  always_comb begin
    item_we    = 1'b0;
    upd        = '0;
    out_result = '0;
    out_result.bin_number = w_entry.number;
    unique case (w_entry.op)
      OP_ADD: begin
        item_we              = 1'b1;
        upd                  = inc;
        out_result.counted   = 1'b1;
        out_result.bin_count = inc32[COUNT_OUT-1:0];
      end
      OP_READ: begin
        out_result.bin_count = cur32[COUNT_OUT-1:0];
      end
      OP_CLEAR: begin
        item_we              = 1'b1;
        out_result.bin_count = cur32[COUNT_OUT-1:0];
      end
      OP_NONE: begin
        out_result.bin_count = '0;
      end
      default: begin
        out_result.bin_count = '0;
      end
    endcase
  end

  // store
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_wa;
  logic [COUNT_BITS-1:0] ram_wd;

  assign ram_we = clearing || (w_go && item_we);
  assign ram_wa = clearing ? clr_addr : w_entry.addr;
  assign ram_wd = clearing ? '0 : upd;

  phh_ram #(
    .WIDTH     (COUNT_BITS),
    .DEPTH     (STORE_SIZE),
    .ADDR_BITS (ADDR_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (q_pop),
    .rd_addr (head.addr),
    .rd_data (rd_data)
  );

  // control: clearing pass, update stage, forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      w_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_BITS'(STORE_SIZE - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (q_pop) begin
        w_valid <= 1'b1;
      end else if (w_go) begin
        w_valid <= 1'b0;
      end
      if (w_go && item_we) begin
        lw_valid <= 1'b1;
      end
    end
  end

  // payload of the update stage and the last write
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_entry <= head;
    end
    if (w_go && item_we) begin
      lw_addr <= w_entry.addr;
      lw_data <= upd;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/point_projection_histogram_unit.sv
// ----------------------------------------------------------------------------
// point_projection_histogram_unit
// Projects 3D points onto a 2D raster and counts them in a bin store; bins
// can be read, or read and cleared.
//
//   channel   direction  handshake         beat
//   input     in         push / full       cmd, point_x/y/z, read_index
//   result    out        pop / empty       counted, bin_number, bin_count
//   config    in         cfg_write         cfg_index, cfg_data
//
// One beat per cycle sustained, through a four-stage front (subtract,
// 32x32 multiply, range check, bin index multiply) and a two-stage back
// (store read, count update and write back). After reset the store is
// zeroed one bin a cycle, with full held high. The front and back stall
// on their own through the queue between them; a held result stalls the
// back first, and the front once that queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module point_projection_histogram_unit #(
  parameter int unsigned MAX_COLUMNS = phh_pkg::DEFAULT_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = phh_pkg::DEFAULT_MAX_ROWS,
  parameter int unsigned COUNT_BITS  = phh_pkg::DEFAULT_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic [15:0]        read_index,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    counted,
  output logic [15:0]             bin_number,
  output logic [15:0]             bin_count
);

  import phh_pkg::*;

  localparam int unsigned STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_BITS   = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned ENTRY_BITS  = OP_BITS + NUMBER_BITS + ADDR_BITS;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_v      <= '0;
      cfg.scale_x       <= '0;
      cfg.scale_v       <= '0;
      cfg.raster_width  <= 9'd256;
      cfg.raster_height <= 9'd256;
      cfg.plane_select  <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        REG_ORIGIN_V:      cfg.origin_v      <= cfg_data;
        REG_SCALE_X:       cfg.scale_x       <= cfg_data;
        REG_SCALE_V:       cfg.scale_v       <= cfg_data;
        REG_RASTER_WIDTH:  cfg.raster_width  <= cfg_data[8:0];
        REG_RASTER_HEIGHT: cfg.raster_height <= cfg_data[8:0];
        REG_PLANE_SELECT:  cfg.plane_select  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // front: accept and classify
  logic                  front_ready;
  logic                  clearing;
  logic                  take;
  logic                  fq_push;
  logic                  fq_full;
  logic                  fq_empty;
  logic                  fq_pop;
  logic [ENTRY_BITS-1:0] fq_in;
  logic [ENTRY_BITS-1:0] fq_out;

  assign full = !front_ready || clearing;
  assign take = push && !full;

  phh_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .STORE_SIZE  (STORE_SIZE),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .cmd        (cmd),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .read_index (read_index),
    .ready      (front_ready),
    .q_push     (fq_push),
    .q_entry    (fq_in),
    .q_full     (fq_full)
  );

  // queue between front and back
  phh_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (FQ_DEPTH)
  ) u_fq (
    .clk     (clk),
    .rst     (rst),
    .wr      (fq_push),
    .wr_data (fq_in),
    .rd      (fq_pop),
    .rd_data (fq_out),
    .empty   (fq_empty),
    .full    (fq_full)
  );

  // back: store update
  logic    oq_push;
  logic    oq_full;
  logic    oq_pop;
  result_t oq_in;
  result_t oq_out;

  phh_back #(
    .STORE_SIZE (STORE_SIZE),
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (fq_empty),
    .q_entry    (fq_out),
    .q_pop      (fq_pop),
    .out_full   (oq_full),
    .out_push   (oq_push),
    .out_result (oq_in),
    .clearing   (clearing)
  );

  // result queue
  assign oq_pop = pop && !empty;

  phh_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_oq (
    .clk     (clk),
    .rst     (rst),
    .wr      (oq_push),
    .wr_data (oq_in),
    .rd      (oq_pop),
    .rd_data (oq_out),
    .empty   (empty),
    .full    (oq_full)
  );

  assign counted    = oq_out.counted;
  assign bin_number = oq_out.bin_number;
  assign bin_count  = oq_out.bin_count;

  // checks
  a_fq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fq_push |-> !fq_full)
    else $error("front queue written while full");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> !oq_full)
    else $error("result queue written while full");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && counted) |-> (bin_count != '0 || COUNT_BITS > 16))
    else $error("counted beat with a zero count");

  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (fq_empty && !fq_pop && !oq_push))
    else $error("store operation during clearing pass");

endmodule

`default_nettype wire
